// ===== hw/rtl/hrst_pkg.sv =====
// ----------------------------------------------------------------------------
// hrst_pkg
// Types and constants shared by the successor table cells, top level and
// checker.
// ----------------------------------------------------------------------------
package hrst_pkg;

    localparam int HRST_CAPACITY = 64;
    localparam int KEY_W         = 32;
    localparam int HANDLE_W      = 32;
    localparam int COUNT_W       = 7;

    localparam logic [KEY_W-1:0] SIGN_BIAS = {1'b1, {(KEY_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [KEY_W-1:0] key;
        logic [HANDLE_W-1:0]     handle;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] found_handle;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_empty;
    } t_rsp;

    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic                ins_go;
        logic                del_go;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_cell_cmd;

    typedef struct packed {
        logic gt;
        logic eq;
    } t_cell_flags;

endpackage

// ===== hw/rtl/hash_ring_successor_table_top.sv =====
// ----------------------------------------------------------------------------
// hash_ring_successor_table_top
// Consistent-hash ring table: a sorted chain of cells holding key/handle
// pairs, serving insert, delete, exact search and ring successor lookup.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             i_req    (t_req)
// response  out        o_strobe, one cycle       o_rsp    (t_rsp)
//
// Each transaction registers the request, then the chain compares against the
// probe and shifts in step, so no new request is taken while busy is high.
// busy is high in the cycle after acceptance, and the response shows on
// o_strobe in the cycle after that and cannot be stalled.
// Synchronous active-low reset empties the chain.
// ----------------------------------------------------------------------------
module hash_ring_successor_table_top
    import hrst_pkg::*;
#(
    parameter int CAPACITY = HRST_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_rsp o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                r_busy;
    logic [1:0]          r_op;
    logic [KEY_W-1:0]    r_key;
    logic [HANDLE_W-1:0] r_handle;
    logic [CW-1:0]       r_count;
    logic                r_strobe;
    t_rsp                r_rsp;
    logic [CW-1:0]       n_count;
    t_rsp                n_rsp;

    t_cell_cmd           cmd;
    t_entry              ent   [CAPACITY];
    t_cell_flags         flg   [CAPACITY];
    t_entry              left  [CAPACITY];
    t_entry              right [CAPACITY];
    logic                lgt   [CAPACITY];
    logic                any_eq;
    logic                full;
    logic [HANDLE_W-1:0] eq_handle;
    logic [HANDLE_W-1:0] succ_handle;
    logic                succ_hit;

    assign busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_strobe <= r_busy;
            if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end else if (start) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_op     <= i_req.operation;
            r_key    <= i_req.key ^ SIGN_BIAS;
            r_handle <= i_req.handle;
        end
        if (r_busy) begin
            r_rsp <= n_rsp;
        end
    end

    assign full = (r_count == CW'(CAPACITY));

    always_comb begin
        any_eq = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            any_eq = any_eq | flg[i].eq;
        end
    end

    always_comb begin
        cmd.ins_go = r_busy && (t_op'(r_op) == OP_INSERT) && !any_eq && !full;
        cmd.del_go = r_busy && (t_op'(r_op) == OP_DELETE) && any_eq;
        cmd.key    = r_key;
        cmd.handle = r_handle;
    end

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_chain
            if (g == 0) begin : g_head
                assign left[g] = '{valid: 1'b1, key: '0, handle: '0};
                assign lgt[g]  = 1'b0;
            end else begin : g_mid
                assign left[g] = ent[g-1];
                assign lgt[g]  = flg[g-1].gt;
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign right[g] = '{valid: 1'b0, key: '0, handle: '0};
            end else begin : g_body
                assign right[g] = ent[g+1];
            end
            hrst_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (cmd),
                .i_left    (left[g]),
                .i_left_gt (lgt[g]),
                .i_right   (right[g]),
                .o_entry   (ent[g]),
                .o_flags   (flg[g])
            );
        end
    endgenerate

    always_comb begin
        logic prev_ge;
        logic ge;
        eq_handle   = '0;
        succ_handle = '0;
        succ_hit    = 1'b0;
        prev_ge     = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            ge = flg[i].gt | flg[i].eq;
            if (flg[i].eq) begin
                eq_handle = eq_handle | ent[i].handle;
            end
            if (ge && !prev_ge) begin
                succ_handle = succ_handle | ent[i].handle;
                succ_hit    = 1'b1;
            end
            prev_ge = ge;
        end
        if (!succ_hit) begin
            succ_handle = ent[0].valid ? ent[0].handle : '0;
        end
    end

    always_comb begin
        n_count            = r_count;
        n_rsp.status       = ST_OK;
        n_rsp.found_handle = '0;
        unique case (t_op'(r_op))
            OP_INSERT: begin
                if (cmd.ins_go) begin
                    n_count = r_count + CW'(1);
                end else if (!any_eq) begin
                    n_rsp.status = ST_FULL;
                end
            end
            OP_DELETE: begin
                if (cmd.del_go) begin
                    n_count = r_count - CW'(1);
                end
            end
            OP_SEARCH: begin
                if (any_eq) begin
                    n_rsp.found_handle = eq_handle;
                end else begin
                    n_rsp.status = ST_MISS;
                end
            end
            OP_LOOKUP: begin
                if (ent[0].valid) begin
                    n_rsp.found_handle = succ_handle;
                end else begin
                    n_rsp.status = ST_MISS;
                end
            end
            default: begin
                n_rsp.status = ST_OK;
            end
        endcase
        n_rsp.entry_count = COUNT_W'(n_count);
        n_rsp.is_empty    = (n_count == '0);
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// ===== hw/rtl/hrst_cell.sv =====
// ----------------------------------------------------------------------------
// hrst_cell
// Sorted-chain slot: holds a key and handle, compares against the broadcast
// probe, and takes its left neighbour or the probe on insert, right on delete.
// ----------------------------------------------------------------------------
module hrst_cell
    import hrst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_cmd   i_cmd,
    input  t_entry      i_left,
    input  logic        i_left_gt,
    input  t_entry      i_right,
    output t_entry      o_entry,
    output t_cell_flags o_flags
);

    logic                r_valid;
    logic [KEY_W-1:0]    r_key;
    logic [HANDLE_W-1:0] r_handle;
    logic                n_valid;
    logic [KEY_W-1:0]    n_key;
    logic [HANDLE_W-1:0] n_handle;
    logic                gt;
    logic                eq;

    always_comb begin
        gt = r_valid && (r_key > i_cmd.key);
        eq = r_valid && (r_key == i_cmd.key);
    end

    always_comb begin
        n_valid  = r_valid;
        n_key    = r_key;
        n_handle = r_handle;
        if (i_cmd.ins_go) begin
            if (i_left_gt) begin
                n_valid  = i_left.valid;
                n_key    = i_left.key;
                n_handle = i_left.handle;
            end else if (gt || (!r_valid && i_left.valid)) begin
                n_valid  = 1'b1;
                n_key    = i_cmd.key;
                n_handle = i_cmd.handle;
            end
        end else if (i_cmd.del_go && (gt || eq)) begin
            n_valid  = i_right.valid;
            n_key    = i_right.key;
            n_handle = i_right.handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

    assign o_entry = '{valid: r_valid, key: r_key, handle: r_handle};
    assign o_flags = '{gt: gt, eq: eq};

endmodule

// ===== hw/rtl/hrst_checker.sv =====
// ----------------------------------------------------------------------------
// hrst_checker
// Port-level checks on the successor table's request/response timing and
// response consistency, bound to the top level.
// ----------------------------------------------------------------------------
module hrst_checker
    import hrst_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input t_rsp o_rsp
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    a_response_two_later: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("response missing two cycles after accepted transaction");

    a_strobe_needs_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("response without a transaction in progress");

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_rsp.is_empty == (o_rsp.entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_full_no_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_rsp.status == ST_FULL || o_rsp.status == ST_MISS))
            |-> (o_rsp.found_handle == '0))
        else $error("handle reported on dropped or missed transaction");

endmodule

bind hash_ring_successor_table_top hrst_checker u_hrst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);
